// ----- rtl/core/kthbs_pkg.sv -----
// shared types and constants of the k-th smallest of two sorted arrays unit
// used by the controller, the datapath and the top level; no dependencies
package kthbs_pkg;

	localparam int VALUE_W = 32;
	localparam int RANK_W  = 12;
	localparam int ELEM_W  = 32;
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 1;
	localparam int RANK_LSB = VALUE_W;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_APPEND_A = 2'd1,
		CMD_APPEND_B = 2'd2,
		CMD_QUERY    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ISSUE,
		ST_READ,
		ST_EVAL,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic clear;
		logic append_a;
		logic append_b;
		logic load_query;
		logic set_err;
		logic init;
		logic issue;
		logic eval;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic full_a;
		logic full_b;
		logic range_err;
		logic hit;
		logic stop;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/core/kthbs_ram.sv -----
// generic single-write, dual-read memory with registered read data
// depends on nothing
module kthbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// ----- rtl/core/kthbs_ctrl.sv -----
// controller state machine: input handshake, search sequencing, result hand-off
// depends on kthbs_pkg
module kthbs_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [kthbs_pkg::S_TUSER_W-1:0]     s_tuser,
	input  kthbs_pkg::stat_t                    st,
	output kthbs_pkg::ctl_t                     ctl
);
	import kthbs_pkg::*;

	state_t state_q;
	state_t state_nxt;
	cmd_t   cmd;

	assign cmd = cmd_t'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (cmd)
						CMD_CLEAR: begin
							ctl.clear = 1'b1;
						end
						CMD_APPEND_A: begin
							if (st.full_a) begin
								ctl.set_err = 1'b1;
								state_nxt   = ST_RESULT;
							end else begin
								ctl.append_a = 1'b1;
							end
						end
						CMD_APPEND_B: begin
							if (st.full_b) begin
								ctl.set_err = 1'b1;
								state_nxt   = ST_RESULT;
							end else begin
								ctl.append_b = 1'b1;
							end
						end
						CMD_QUERY: begin
							ctl.load_query = 1'b1;
							state_nxt      = ST_CHECK;
						end
						default: begin
							state_nxt = ST_IDLE;
						end
					endcase
				end
			end
			ST_CHECK: begin
				if (st.range_err) begin
					ctl.set_err = 1'b1;
					state_nxt   = ST_RESULT;
				end else begin
					ctl.init  = 1'b1;
					state_nxt = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				ctl.issue = 1'b1;
				state_nxt = ST_READ;
			end
			ST_READ: begin
				state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				ctl.eval = 1'b1;
				if (st.hit || st.stop) begin
					state_nxt = ST_RESULT;
				end else begin
					state_nxt = ST_ISSUE;
				end
			end
			ST_RESULT: begin
				if (st.out_free) begin
					ctl.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> $past(state_q) == ST_READ)
		else $error("eval not preceded by read");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && !st.out_free) |=> state_q == ST_RESULT)
		else $error("result dropped while output busy");

	a_query_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && cmd == CMD_QUERY) |=> state_q == ST_CHECK)
		else $error("query did not start range check");

endmodule

// ----- rtl/core/kthbs_dp.sv -----
// datapath: both element memories, counts, binary search registers, output register
// depends on kthbs_pkg and kthbs_ram
module kthbs_dp #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kthbs_pkg::ctl_t                   ctl,
	output kthbs_pkg::stat_t                  st,
	input  logic signed [kthbs_pkg::VALUE_W-1:0] value,
	input  logic [kthbs_pkg::RANK_W-1:0]      rank,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [kthbs_pkg::ELEM_W-1:0] element,
	output logic                              error
);
	import kthbs_pkg::*;

	localparam int AW = $clog2(ARRAY_DEPTH);
	localparam int CW = $clog2(ARRAY_DEPTH + 1);
	localparam int KW = (CW + 1 > RANK_W) ? CW + 1 : RANK_W;
	localparam int EW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic [KW-1:0] k_q;
	logic          swap_q;
	logic [CW-1:0] ma_q, nb_q, low_q, high_q, c1_q, c2_q;
	logic          res_err_q;
	logic [DATA_WIDTH-1:0] res_elem_q;
	logic          out_valid_q;
	logic [ELEM_W-1:0] out_elem_q;
	logic          out_err_q;

	logic [EW-1:0]         value_ext, elem_ext;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
	logic [AW-1:0]         addr_a0, addr_a1, addr_b0, addr_b1;
	logic [CW-1:0]         c1m, c2m;
	logic [CW:0]           total, mid_sum;
	logic                  swap_n;
	logic [CW-1:0]         ma_n, nb_n, low_n, high_n, c1_n, c2_n;
	logic [KW-1:0]         c2_wide;
	logic [DATA_WIDTH-1:0] l1, r1, l2, r2, pick;
	logic                  h_l1, h_r1, h_l2, h_r2, ok1, ok2;

	function automatic logic [CW-1:0] c1_m1_safe(input logic [CW-1:0] c);
		c1_m1_safe = c - CW'(1);
	endfunction

	// storage and counts
	assign value_ext = EW'($unsigned(value));
	assign wdata     = value_ext[DATA_WIDTH-1:0];

	kthbs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ARRAY_DEPTH)) u_ram_a (
		.clk    (clk),
		.we     (ctl.append_a),
		.waddr  (cnt_a_q[AW-1:0]),
		.wdata  (wdata),
		.raddr0 (addr_a0),
		.raddr1 (addr_a1),
		.rdata0 (rd_a0),
		.rdata1 (rd_a1)
	);

	kthbs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ARRAY_DEPTH)) u_ram_b (
		.clk    (clk),
		.we     (ctl.append_b),
		.waddr  (cnt_b_q[AW-1:0]),
		.wdata  (wdata),
		.raddr0 (addr_b0),
		.raddr1 (addr_b1),
		.rdata0 (rd_b0),
		.rdata1 (rd_b1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
			end
			if (ctl.append_a) begin
				cnt_a_q <= cnt_a_q + CW'(1);
			end
			if (ctl.append_b) begin
				cnt_b_q <= cnt_b_q + CW'(1);
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search setup
	assign total  = {1'b0, cnt_a_q} + {1'b0, cnt_b_q};
	assign swap_n = cnt_a_q > cnt_b_q;
	assign ma_n   = swap_n ? cnt_b_q : cnt_a_q;
	assign nb_n   = swap_n ? cnt_a_q : cnt_b_q;

	always_comb begin
		low_n  = '0;
		high_n = ma_n;
		if (k_q > KW'(nb_n)) begin
			c2_wide = k_q - KW'(nb_n);
			low_n   = c2_wide[CW-1:0];
		end else begin
			c2_wide = '0;
		end
		if (k_q < KW'(ma_n)) begin
			high_n = k_q[CW-1:0];
		end
	end

	// cut points
	assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
	assign c1_n    = mid_sum[CW:1];

	always_comb begin
		logic [KW-1:0] diff;
		diff = k_q - KW'(c1_n);
		c2_n = diff[CW-1:0];
	end

	assign c1m     = c1_q - CW'(1);
	assign c2m     = c2_q - CW'(1);
	assign addr_a0 = swap_q ? c2m[AW-1:0]  : c1m[AW-1:0];
	assign addr_a1 = swap_q ? c2_q[AW-1:0] : c1_q[AW-1:0];
	assign addr_b0 = swap_q ? c1m[AW-1:0]  : c2m[AW-1:0];
	assign addr_b1 = swap_q ? c1_q[AW-1:0] : c2_q[AW-1:0];

	// compare at the cut
	assign l1 = swap_q ? rd_b0 : rd_a0;
	assign r1 = swap_q ? rd_b1 : rd_a1;
	assign l2 = swap_q ? rd_a0 : rd_b0;
	assign r2 = swap_q ? rd_a1 : rd_b1;

	assign h_l1 = c1_q != '0;
	assign h_r1 = c1_q < ma_q;
	assign h_l2 = c2_q != '0;
	assign h_r2 = c2_q < nb_q;
	assign ok1  = !h_l1 || !h_r2 || ($signed(l1) <= $signed(r2));
	assign ok2  = !h_l2 || !h_r1 || ($signed(l2) <= $signed(r1));

	always_comb begin
		if (h_l1 && h_l2) begin
			pick = ($signed(l1) > $signed(l2)) ? l1 : l2;
		end else if (h_l1) begin
			pick = l1;
		end else begin
			pick = l2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_query) begin
			k_q <= KW'(rank);
		end
		if (ctl.init) begin
			swap_q <= swap_n;
			ma_q   <= ma_n;
			nb_q   <= nb_n;
			low_q  <= low_n;
			high_q <= high_n;
		end
		if (ctl.issue) begin
			c1_q <= c1_n;
			c2_q <= c2_n;
		end
		if (ctl.set_err) begin
			res_err_q  <= 1'b1;
			res_elem_q <= '0;
		end
		if (ctl.eval) begin
			if (ok1 && ok2) begin
				res_err_q  <= !(h_l1 || h_l2);
				res_elem_q <= (h_l1 || h_l2) ? pick : '0;
			end else begin
				res_err_q  <= 1'b1;
				res_elem_q <= '0;
				if (!ok1) begin
					high_q <= c1_m1_safe(c1_q);
				end else begin
					low_q <= c1_q + CW'(1);
				end
			end
		end
		if (ctl.load_out) begin
			out_elem_q <= elem_ext[ELEM_W-1:0];
			out_err_q  <= res_err_q;
		end
	end

	assign elem_ext = EW'(res_elem_q);

	// status
	assign st.full_a    = cnt_a_q == CW'(ARRAY_DEPTH);
	assign st.full_b    = cnt_b_q == CW'(ARRAY_DEPTH);
	assign st.range_err = (k_q == '0) || (k_q > KW'(total));
	assign st.hit       = ok1 && ok2;
	assign st.stop      = !(ok1 && ok2) && ((!ok1 && c1_q == low_q) || (ok1 && c1_q == high_q));
	assign st.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign element   = out_elem_q;
	assign error     = out_err_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_a_q <= CW'(ARRAY_DEPTH) && cnt_b_q <= CW'(ARRAY_DEPTH))
		else $error("array count above depth");

	a_window_open: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue |-> low_q <= high_q)
		else $error("search window empty at issue");

	a_cut_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.eval |-> (c1_q >= low_q && c1_q <= high_q))
		else $error("cut outside search window");

endmodule

// ----- rtl/core/kth_of_two_sorted_binary_search_unit.sv -----
// top level of the k-th smallest of two sorted arrays unit
// depends on kthbs_pkg, kthbs_ctrl and kthbs_dp
//
// usage
//  one input stream carries commands: s_tuser is the command (clear both
//  arrays, append to the first, append to the second, query) and s_tdata
//  holds the value to append and the one-based rank of a query
//  appends must keep each array nondecreasing; a query answers with the
//  rank-th smallest element of both arrays on the output stream
//  clears and accepted appends give no item
//  an append to a full array gives one item with the error flag set
//  a query gives one item; error is set and element is zero when the rank
//  is zero or above the total count
//  query: a range check, then binary search steps (up to clog2(depth + 1)
//  steps, one per halving of the shorter array), each issuing the reads,
//  waiting on them and evaluating the cut, then a load into the output register;
//  the search is paced by the registered read of both element memories
//  a result that is not taken stays in the output register; the unit stops
//  accepting items until it has one ready and the register is free
//  reset empties both arrays and drops any pending item
module kth_of_two_sorted_binary_search_unit #(
	parameter int ARRAY_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [kthbs_pkg::S_TDATA_W-1:0]       s_tdata,  // value[31:0], rank[43:32]
	input  logic [kthbs_pkg::S_TUSER_W-1:0]       s_tuser,  // cmd[1:0]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [kthbs_pkg::M_TDATA_W-1:0]       m_tdata,  // element[31:0]
	output logic [kthbs_pkg::M_TUSER_W-1:0]       m_tuser   // error[0]
);
	import kthbs_pkg::*;

	ctl_t ctl;
	stat_t st;
	logic signed [VALUE_W-1:0] value;
	logic [RANK_W-1:0]         rank;
	logic signed [ELEM_W-1:0]  element;
	logic                      error;

	assign value = s_tdata[VALUE_W-1:0];
	assign rank  = s_tdata[RANK_LSB +: RANK_W];

	kthbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.st       (st),
		.ctl      (ctl)
	);

	kthbs_dp #(.ARRAY_DEPTH(ARRAY_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.value     (value),
		.rank      (rank),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.element   (element),
		.error     (error)
	);

	assign m_tdata = element;
	assign m_tuser = error;

endmodule

// ----- sim/kth_rank_checker.sv -----
`timescale 1ns / 1ps
// checker for the k-th smallest of two sorted arrays unit: watches both streams,
// keeps its own copy of the two arrays, predicts each answer and compares it
// depends on kthbs_pkg
module kth_rank_checker #(
	parameter int ARRAY_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [kthbs_pkg::S_TDATA_W-1:0]   s_tdata,  // value[31:0], rank[43:32]
	input  logic [kthbs_pkg::S_TUSER_W-1:0]   s_tuser,  // cmd[1:0]
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [kthbs_pkg::M_TDATA_W-1:0]   m_tdata,  // element[31:0]
	input  logic [kthbs_pkg::M_TUSER_W-1:0]   m_tuser,  // error[0]
	output int                                fail_count,
	output int                                outstanding
);
	import kthbs_pkg::*;

	typedef struct packed {
		logic [ELEM_W-1:0] element;
		logic              error;
	} answer_t;

	localparam answer_t ERROR_ANSWER = '{element: '0, error: 1'b1};

	answer_t expected_answers[$];
	logic signed [VALUE_W-1:0] first_elems[ARRAY_DEPTH];
	logic signed [VALUE_W-1:0] second_elems[ARRAY_DEPTH];
	int first_len = 0;
	int second_len = 0;
	int mismatches = 0;

	function automatic logic signed [VALUE_W-1:0] read_entry(input bit from_second,
		input int idx);
		return from_second ? second_elems[idx] : first_elems[idx];
	endfunction

	// binary search for the cut in the shorter array; edge cuts act as -inf / +inf
	function automatic bit search_kth(input bit short_second, input int k,
		output logic signed [VALUE_W-1:0] found);
		int m, n, lo, hi, c1, c2;
		bit hl1, hl2, hr1, hr2, ok1, ok2;
		logic signed [VALUE_W-1:0] l1, l2, r1, r2;
		m = short_second ? second_len : first_len;
		n = short_second ? first_len : second_len;
		lo = (k - n > 0) ? k - n : 0;
		hi = (k < m) ? k : m;
		found = '0;
		while (lo <= hi) begin
			c1 = (lo + hi) / 2;
			c2 = k - c1;
			hl1 = c1 > 0;
			hl2 = c2 > 0;
			hr1 = c1 < m;
			hr2 = c2 < n;
			l1 = hl1 ? read_entry(short_second, c1 - 1) : '0;
			l2 = hl2 ? read_entry(!short_second, c2 - 1) : '0;
			r1 = hr1 ? read_entry(short_second, c1) : '0;
			r2 = hr2 ? read_entry(!short_second, c2) : '0;
			ok1 = !hl1 || !hr2 || (l1 <= r2);
			ok2 = !hl2 || !hr1 || (l2 <= r1);
			if (ok1 && ok2) begin
				if (hl1 && hl2)
					found = (l1 > l2) ? l1 : l2;
				else if (hl1)
					found = l1;
				else if (hl2)
					found = l2;
				return hl1 || hl2;
			end
			if (!ok1)
				hi = c1 - 1;
			else
				lo = c1 + 1;
		end
		return 1'b0;
	endfunction

	task automatic predict_answer(input cmd_t op, input logic [VALUE_W-1:0] value,
		input logic [RANK_W-1:0] rank);
		logic signed [VALUE_W-1:0] elem;
		int k;
		k = int'(rank);
		case (op)
			CMD_CLEAR: begin
				first_len = 0;
				second_len = 0;
			end
			CMD_APPEND_A: begin
				if (first_len >= ARRAY_DEPTH) begin
					expected_answers.push_back(ERROR_ANSWER);
				end else begin
					first_elems[first_len] = value;
					first_len++;
				end
			end
			CMD_APPEND_B: begin
				if (second_len >= ARRAY_DEPTH) begin
					expected_answers.push_back(ERROR_ANSWER);
				end else begin
					second_elems[second_len] = value;
					second_len++;
				end
			end
			default: begin
				if (k < 1 || k > first_len + second_len)
					expected_answers.push_back(ERROR_ANSWER);
				else if (search_kth(first_len > second_len, k, elem))
					expected_answers.push_back('{element: elem, error: 1'b0});
				else
					expected_answers.push_back(ERROR_ANSWER);
			end
		endcase
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("kth_rank_checker: mismatch %0d at %0t: %s", mismatches, $realtime, what);
	endtask

	always @(posedge clk) begin : watch_streams
		answer_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{element: m_tdata, error: m_tuser[0]};
				if (expected_answers.size() == 0) begin
					report_mismatch($sformatf("item with nothing expected, element %0d error %0b",
						$signed(got.element), got.error));
				end else begin
					want = expected_answers.pop_front();
					if (got.element !== want.element)
						report_mismatch($sformatf("element expected %0d, got %0d",
							$signed(want.element), $signed(got.element)));
					if (got.error !== want.error)
						report_mismatch($sformatf("error flag expected %0b, got %0b",
							want.error, got.error));
				end
			end
			if (s_tvalid && s_tready)
				predict_answer(cmd_t'(s_tuser), s_tdata[VALUE_W-1:0],
					s_tdata[RANK_LSB +: RANK_W]);
		end
		fail_count <= mismatches;
		outstanding <= expected_answers.size();
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// top of the testbench for kth_of_two_sorted_binary_search_unit: drives commands
// and output stalls, gives the verdict; depends on kthbs_pkg and kth_rank_checker
module testbench;
	import kthbs_pkg::*;

	localparam int ARRAY_DEPTH = 1024;
	localparam int RANDOM_ITEMS = 1000;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 64;
	localparam longint MAX_VALUE = 64'sd2147483647;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = CMD_CLEAR;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	int fail_count;
	int outstanding;
	int quiet_cycles = 0;
	int items_sent = 0;
	int count_a = 0;
	int count_b = 0;
	int value_step = 3;
	longint tail_a = 0;
	longint tail_b = 0;
	bit send_gaps = 1'b1;
	bit take_gaps = 1'b1;

	always #2 clk = ~clk;

	kth_of_two_sorted_binary_search_unit #(
		.ARRAY_DEPTH(ARRAY_DEPTH),
		.DATA_WIDTH (32)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	kth_rank_checker #(
		.ARRAY_DEPTH(ARRAY_DEPTH)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic send_item(input cmd_t op, input logic [VALUE_W-1:0] value,
		input logic [RANK_W-1:0] rank);
		int gap;
		gap = send_gaps ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_TDATA_W - RANK_LSB - RANK_W){1'b0}}, rank, value};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		case (op)
			CMD_CLEAR: begin
				count_a = 0;
				count_b = 0;
			end
			CMD_APPEND_A: if (count_a < ARRAY_DEPTH) count_a++;
			CMD_APPEND_B: if (count_b < ARRAY_DEPTH) count_b++;
			default: ;
		endcase
	endtask

	task automatic restart_arrays(input bit wide);
		int offset;
		value_step = wide ? (1 << 28) : 3;
		offset = wide ? $urandom : $urandom_range(0, 10) - 20;
		tail_a = offset;
		offset = wide ? $urandom : $urandom_range(0, 10) - 20;
		tail_b = offset;
		send_item(CMD_CLEAR, $urandom, 12'($urandom_range(0, 4095)));
	endtask

	task automatic append_sorted(input bit second);
		int step;
		step = $urandom_range(0, value_step);
		if (second) begin
			tail_b = (tail_b + step > MAX_VALUE) ? MAX_VALUE : tail_b + step;
			send_item(CMD_APPEND_B, 32'(tail_b), 12'($urandom_range(0, 4095)));
		end else begin
			tail_a = (tail_a + step > MAX_VALUE) ? MAX_VALUE : tail_a + step;
			send_item(CMD_APPEND_A, 32'(tail_a), 12'($urandom_range(0, 4095)));
		end
	endtask

	task automatic ask_rank();
		int total, pick, rank;
		total = count_a + count_b;
		pick = $urandom_range(0, 9);
		case (pick)
			0: rank = $urandom_range(0, 4095);
			1: rank = total + 1;
			2: rank = total;
			3: rank = 1;
			default: rank = (total == 0) ? 0 : $urandom_range(1, total);
		endcase
		send_item(CMD_QUERY, $urandom, rank[RANK_W-1:0]);
	endtask

	initial begin
		int wait_cycles;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				take_gaps = !take_gaps;
			wait_cycles = take_gaps ? $urandom_range(0, 15) : 0;
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		int kind, burst, random_end;
		bit wide, must_clear;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty arrays, rank zero, extreme values, duplicates at the top
		send_item(CMD_QUERY, '0, 12'd1);
		send_item(CMD_QUERY, '0, 12'd0);
		send_item(CMD_APPEND_A, 32'h8000_0000, '0);
		send_item(CMD_APPEND_A, 32'h0000_0000, 12'hfff);
		send_item(CMD_APPEND_A, 32'h7fff_ffff, '0);
		send_item(CMD_APPEND_B, -32'sd5, '0);
		send_item(CMD_APPEND_B, 32'h7fff_ffff, '0);
		for (int r = 1; r <= 6; r++)
			send_item(CMD_QUERY, 32'hffff_ffff, 12'(r));
		send_item(CMD_QUERY, '0, 12'hfff);
		send_item(CMD_CLEAR, '0, '0);
		send_item(CMD_QUERY, '0, 12'd1);
		// one array empty, then unsorted contents
		send_item(CMD_APPEND_B, 32'd7, '0);
		send_item(CMD_QUERY, '0, 12'd1);
		send_item(CMD_APPEND_A, 32'd10, '0);
		send_item(CMD_APPEND_A, 32'd3, '0);
		for (int r = 1; r <= 3; r++)
			send_item(CMD_QUERY, '0, 12'(r));

		must_clear = 1'b1;
		random_end = items_sent + RANDOM_ITEMS;
		while (items_sent < random_end) begin
			send_gaps = $urandom_range(0, 3) != 0;
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				if (must_clear || $urandom_range(0, 3) == 0) begin
					wide = 1'($urandom_range(0, 1));
					restart_arrays(wide);
				end
				must_clear = (kind == 7);
				burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
					: $urandom_range(0, 12);
				repeat (burst) begin
					append_sorted(1'($urandom_range(0, 1)));
					if ($urandom_range(0, 5) == 0)
						ask_rank();
				end
				// out of order element breaks the sorted contents
				if (kind == 7)
					send_item(cmd_t'($urandom_range(1, 2)), $urandom,
						12'($urandom_range(0, 4095)));
				repeat ($urandom_range(1, 8)) ask_rank();
			end else begin
				must_clear = 1'b1;
				repeat ($urandom_range(1, 10))
					send_item(cmd_t'($urandom_range(0, 3)), $urandom,
						12'($urandom_range(0, 4095)));
			end
		end

		// largest ranks on the last contents
		send_gaps = 1'b1;
		send_item(CMD_QUERY, '0, 12'd2048);
		send_item(CMD_QUERY, '0, 12'd2049);
		repeat (8) ask_rank();

		s_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
